@@ rtl/core/wto_pkg.sv @@
package wto_pkg;

  // default build values
  localparam int TABLE_ENTRIES_DEF = 1000;
  localparam int FRACTION_BITS_DEF = 16;

  // fixed field widths
  localparam int IDX_W   = 10;
  localparam int VAL_W   = 17;
  localparam int SMP_W   = 16;
  localparam int STEP_W  = 26;
  localparam int TOTAL_W = 32;

  // config port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_PHASE_STEP   = 1'b0;
  localparam logic REG_SAMPLE_TOTAL = 1'b1;

  // item modes
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // front/back queue
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic                    is_tick;
    logic [IDX_W-1:0]        idx;
    logic signed [VAL_W-1:0] value;
  } qent_t;

  function automatic logic signed [SMP_W-1:0] sat16(logic signed [VAL_W-1:0] v);
    logic signed [SMP_W-1:0] r;
    if (v[VAL_W-1] != v[SMP_W-1]) begin
      r = v[VAL_W-1] ? {1'b1, {(SMP_W-1){1'b0}}} : {1'b0, {(SMP_W-1){1'b1}}};
    end else begin
      r = v[SMP_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/core/wto_ifs.sv @@
interface wto_in_if import wto_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    mode;
  logic [IDX_W-1:0]        entry_index;
  logic signed [VAL_W-1:0] entry_value;

  modport source (output valid, mode, entry_index, entry_value, input ready);
  modport sink (input valid, mode, entry_index, entry_value, output ready);
endinterface

interface wto_out_if import wto_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [SMP_W-1:0] left_sample;
  logic signed [SMP_W-1:0] right_sample;
  logic                    is_last;

  modport source (output valid, left_sample, right_sample, is_last, input ready);
  modport sink (input valid, left_sample, right_sample, is_last, output ready);
endinterface

@@ rtl/core/wavetable_oscillator.sv @@
// A tick item passes the queue, table read register and output register to sample_o.
// Throughput: one item per cycle, loads and ticks alike, unless busy or sample_o stalls;
// one table read per tick. A phase_step write holds item processing through ST_MUL and
// ST_FIX while the step is reduced modulo the table length (one multiply per cycle).
// Reset: phase, sample count, registers and queue clear; table contents are undefined
// until loaded, with no clearing pass.
module wavetable_oscillator import wto_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  wto_in_if.sink             item_i,
  wto_out_if.source          sample_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int PW = $clog2(TABLE_ENTRIES) + FRACTION_BITS;

  qent_t              head;
  logic               head_valid;
  logic               pop;
  logic [PW-1:0]      step_red;
  logic [TOTAL_W-1:0] total;
  logic               busy;

  wto_cfg #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .step_red_o (step_red),
    .total_o    (total),
    .busy_o     (busy)
  );

  wto_front #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_if        (item_i),
    .head_o       (head),
    .head_valid_o (head_valid),
    .pop_i        (pop)
  );

  wto_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (head_valid),
    .pop_o        (pop),
    .step_red_i   (step_red),
    .total_i      (total),
    .busy_i       (busy),
    .out_if       (sample_o)
  );

endmodule

@@ rtl/core/wto_ram.sv @@
module wto_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 1000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/wto_cfg.sv @@
module wto_cfg import wto_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output logic [$clog2(TABLE_ENTRIES)+FRACTION_BITS-1:0] step_red_o,
  output logic [TOTAL_W-1:0] total_o,
  output logic               busy_o
);

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int PW = AW + FRACTION_BITS;
  localparam int XW = STEP_W - FRACTION_BITS;
  localparam int TW = $clog2(TABLE_ENTRIES + 1);
  localparam int SH = XW + TW;
  localparam longint unsigned RECIP = (64'd1 << SH) / TABLE_ENTRIES;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_FIX
  } state_e;

  state_e              state_q;
  logic [STEP_W-1:0]   step_q;
  logic [TOTAL_W-1:0]  total_q;
  logic [XW-1:0]       quo_q;
  logic [PW-1:0]       step_red_q;

  logic                wr_en;
  logic [XW-1:0]       whole;
  logic [XW+SH-1:0]    prod;
  logic [XW+TW-1:0]    qt;
  logic [XW+TW-1:0]    rem;
  logic [XW+TW-1:0]    rem_fix;
  logic [PW-1:0]       step_red_d;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_SAMPLE_TOTAL) ? total_q
                                                 : PDATA_W'(step_q);

  // step mod (entries << frac): only the integer part needs reducing
  assign whole   = step_q[STEP_W-1:FRACTION_BITS];
  assign prod    = (XW+SH)'(whole) * (XW+SH)'(RECIP);
  assign qt      = (XW+TW)'(quo_q) * (XW+TW)'(TABLE_ENTRIES);
  assign rem     = (XW+TW)'(whole) - qt;
  assign rem_fix = (rem >= (XW+TW)'(TABLE_ENTRIES)) ? rem - (XW+TW)'(TABLE_ENTRIES) : rem;
  assign step_red_d = {AW'(rem_fix), step_q[FRACTION_BITS-1:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      step_q     <= '0;
      total_q    <= '0;
      quo_q      <= '0;
      step_red_q <= '0;
    end else begin
      if (wr_en && (paddr[2] == REG_PHASE_STEP)) begin
        step_q  <= pwdata[STEP_W-1:0];
        state_q <= ST_MUL;
      end else begin
        case (state_q)
          ST_MUL: begin
            quo_q   <= prod[XW+SH-1:SH];
            state_q <= ST_FIX;
          end
          ST_FIX: begin
            step_red_q <= step_red_d;
            state_q    <= ST_IDLE;
          end
          default: begin
            state_q <= ST_IDLE;
          end
        endcase
      end
      if (wr_en && (paddr[2] == REG_SAMPLE_TOTAL)) begin
        total_q <= pwdata[TOTAL_W-1:0];
      end
    end
  end

  assign step_red_o = step_red_q;
  assign total_o    = total_q;
  assign busy_o     = (state_q != ST_IDLE);

  a_mul_then_fix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL && !wr_en) |=> (state_q == ST_FIX))
    else $error("step reduction skipped fix stage");

  a_red_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIX) |-> (rem_fix < (XW+TW)'(TABLE_ENTRIES)))
    else $error("reduced step out of range");

  a_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && paddr[2] == REG_PHASE_STEP) |=> busy_o)
    else $error("step write did not start reduction");

endmodule

@@ rtl/core/wto_front.sv @@
module wto_front import wto_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  wto_in_if.sink      in_if,
  output qent_t       head_o,
  output logic        head_valid_o,
  input  logic        pop_i
);

  qent_t             slot_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              accept, push, keep;

  assign in_if.ready = (count_q != QCNT_W'(QDEPTH));
  assign accept      = in_if.valid && in_if.ready;
  // loads past the table end are dropped here
  assign keep = (in_if.mode == MODE_TICK) || (32'(in_if.entry_index) < TABLE_ENTRIES);
  assign push = accept && keep;

  assign head_o       = slot_q[rd_ptr_q];
  assign head_valid_o = (count_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= '{is_tick: (in_if.mode == MODE_TICK),
                            idx:     in_if.entry_index,
                            value:   in_if.entry_value};
    end
  end

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QDEPTH))
    else $error("queue overflow");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_valid_o)
    else $error("pop from empty queue");

  a_ptr_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    QPTR_W'(wr_ptr_q - rd_ptr_q) == QPTR_W'(count_q))
    else $error("queue pointers disagree with count");

endmodule

@@ rtl/core/wto_back.sv @@
module wto_back import wto_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  qent_t               head_i,
  input  logic                head_valid_i,
  output logic                pop_o,
  input  logic [$clog2(TABLE_ENTRIES)+FRACTION_BITS-1:0] step_red_i,
  input  logic [TOTAL_W-1:0]  total_i,
  input  logic                busy_i,
  wto_out_if.source           out_if
);

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int PW = AW + FRACTION_BITS;
  localparam logic [PW:0] PHASE_MOD = (PW+1)'(TABLE_ENTRIES) << FRACTION_BITS;

  logic [PW-1:0]           phase_q, phase_d;
  logic [PW:0]             phase_sum;
  logic [TOTAL_W-1:0]      done_q, done_d;
  logic                    s1_valid_q, s1_last_q;
  logic                    out_valid_q, out_last_q;
  logic signed [SMP_W-1:0] out_smp_q;
  logic [VAL_W-1:0]        rdata;
  logic                    move_s1, pop, fire, wr_en;

  assign move_s1 = s1_valid_q && (!out_valid_q || out_if.ready);
  assign pop     = head_valid_i && !busy_i
                   && (!head_i.is_tick || !s1_valid_q || move_s1);
  assign fire    = pop && head_i.is_tick && (done_q < total_i);
  assign wr_en   = pop && !head_i.is_tick;
  assign pop_o   = pop;

  // phase and step are both below the modulus: one conditional subtract
  assign phase_sum = {1'b0, phase_q} + {1'b0, step_red_i};
  assign phase_d   = (phase_sum >= PHASE_MOD) ? PW'(phase_sum - PHASE_MOD)
                                              : PW'(phase_sum);
  assign done_d    = done_q + 1'b1;

  wto_ram #(
    .WIDTH (VAL_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (AW'(head_i.idx)),
    .wdata_i (head_i.value),
    .re_i    (fire),
    .raddr_i (phase_d[PW-1:FRACTION_BITS]),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= '0;
      done_q      <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        phase_q <= phase_d;
        done_q  <= done_d;
      end
      if (fire) begin
        s1_valid_q <= 1'b1;
      end else if (move_s1) begin
        s1_valid_q <= 1'b0;
      end
      if (move_s1) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      s1_last_q <= (done_d == total_i);
    end
    if (move_s1) begin
      out_smp_q  <= sat16(rdata);
      out_last_q <= s1_last_q;
    end
  end

  assign out_if.valid        = out_valid_q;
  assign out_if.left_sample  = out_smp_q;
  assign out_if.right_sample = out_smp_q;
  assign out_if.is_last      = out_last_q;

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, phase_q} < PHASE_MOD)
    else $error("phase out of range");

  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_i |-> !pop_o)
    else $error("item taken during step reduction");

  a_s1_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !out_if.ready) |=> s1_valid_q)
    else $error("read stage lost a sample under stall");

endmodule
